[sv/xlks_pkg.sv]
`default_nettype none

package xlks_pkg;

  localparam int WordW = 32;
  localparam int StepW = 10;
  localparam int CmdW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_SEED       = 2'd0,
    CMD_DESCRAMBLE = 2'd1,
    CMD_ADVANCE    = 2'd2,
    CMD_HOLD       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // Bit reversal of one word; every output bit is an independent wire.
  function automatic logic [WordW-1:0] reverse_word(input logic [WordW-1:0] v);
    logic [WordW-1:0] r;
    for (int b = 0; b < WordW; b++) begin
      r[b] = v[WordW-1-b];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/xnor_lfsr_key_scrambler.sv]
`default_nettype none

// Channel   Dir  Payload (lowest bit up)                    Handshake
// s_axis    in   tuser: cmd[1:0]                            tvalid/tready
//                tdata: data_word[31:0], step_count[41:32]
// m_axis    out  tdata: result_word[31:0], key_after[63:32] tvalid/tready
//
// An input beat is accepted in idle; run then steps the working word once per unit of
// step_count (saturated to 2^COUNT_BITS - 1), or a zero count or hold command goes
// straight to finish, which registers the result. A new beat is taken only in idle.
// The single LFSR step unit advances the working word one bit per cycle in run. The
// input side is ready only while the sequencer is idle; a stalled master side keeps
// it waiting in the finish state. Reset clears the key and the output valid flag.
module xnor_lfsr_key_scrambler
  import xlks_pkg::*;
#(
  parameter int COUNT_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // data_word[31:0], step_count[41:32], zero pad
  input  logic [1:0]  s_axis_tuser_i,   // cmd[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // result_word[31:0], key_after[63:32]
);

  localparam int SatW = (COUNT_BITS > StepW) ? COUNT_BITS : StepW;

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [WordW-1:0] work_q, work_d;
  logic [WordW-1:0] key_q, key_d;
  logic [WordW-1:0] xor_q, xor_d;
  logic [WordW-1:0] res_q, res_d;
  logic [WordW-1:0] kaf_q, kaf_d;
  logic out_valid_q, out_valid_d;

  logic [WordW-1:0] in_data;
  logic [StepW-1:0] in_steps;
  cmd_e             in_cmd;
  logic             in_fire;
  logic             out_free;
  logic [SatW-1:0]  steps_ext;
  logic [SatW-1:0]  steps_lim;
  logic [COUNT_BITS-1:0] steps_sat;

  logic [WordW-1:0] step_word;
  logic [WordW-1:0] final_word;

  assign in_data  = s_axis_tdata_i[WordW-1:0];
  assign in_steps = s_axis_tdata_i[WordW+StepW-1:WordW];
  assign in_cmd   = cmd_e'(s_axis_tuser_i);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // The step count saturates at the largest value the counter can hold.
  assign steps_ext = SatW'(in_steps);
  assign steps_lim = SatW'((64'd1 << COUNT_BITS) - 64'd1);
  assign steps_sat = (steps_ext > steps_lim) ? steps_lim[COUNT_BITS-1:0]
                                             : steps_ext[COUNT_BITS-1:0];

  // The shared step unit runs right for seeding and left for key advances.
  xlks_lfsr_step u_step (
    .word_i  (work_q),
    .right_i (cmd_q == CMD_SEED),
    .step_o  (step_word),
    .final_o (final_word)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (steps_sat == '0 || in_cmd == CMD_HOLD) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (cnt_q == COUNT_BITS'(1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    work_d      = work_q;
    key_d       = key_q;
    xor_d       = xor_q;
    res_d       = res_q;
    kaf_d       = kaf_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d  = in_cmd;
          cnt_d  = steps_sat;
          work_d = (in_cmd == CMD_SEED) ? in_data : key_q;
          // The descramble result uses the key as it stood before the advance.
          xor_d  = in_data ^ key_q;
        end
      end
      ST_RUN: begin
        work_d = step_word;
        cnt_d  = cnt_q - COUNT_BITS'(1);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          case (cmd_q)
            CMD_SEED: begin
              key_d = reverse_word(final_word);
              res_d = reverse_word(final_word);
              kaf_d = reverse_word(final_word);
            end
            CMD_DESCRAMBLE: begin
              key_d = final_word;
              res_d = xor_q;
              kaf_d = final_word;
            end
            CMD_ADVANCE: begin
              key_d = final_word;
              res_d = final_word;
              kaf_d = final_word;
            end
            default: begin
              res_d = key_q;
              kaf_d = key_q;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      cmd_q       <= CMD_SEED;
    end else begin
      state_q     <= state_d;
      key_q       <= key_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      cmd_q       <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    xor_q  <= xor_d;
    res_q  <= res_d;
    kaf_q  <= kaf_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {kaf_q, res_q};

endmodule

`default_nettype wire

[sv/xlks_lfsr_step.sv]
`default_nettype none

// One XNOR LFSR step in either direction, plus the final feedback insertion.
module xlks_lfsr_step
  import xlks_pkg::*;
(
  input  logic [WordW-1:0] word_i,
  input  logic             right_i,
  output logic [WordW-1:0] step_o,
  output logic [WordW-1:0] final_o
);

  logic fb_right;
  logic fb_left;

  assign fb_right = ~(word_i[0] ^ word_i[7] ^ word_i[15] ^ word_i[23]);
  assign fb_left  = ~(word_i[31] ^ word_i[24] ^ word_i[16] ^ word_i[8]);

  always_comb begin
    if (right_i) begin
      // Shift right; the feedback is ORed into bit 30 over the shifted-in top bit.
      step_o  = {1'b0, word_i[31] | fb_right, word_i[30:1]};
      final_o = {word_i[31] | fb_right, word_i[30:0]};
    end else begin
      // Shift left; the feedback is ORed into bit 1 over the old bit 0.
      step_o  = {word_i[30:1], word_i[0] | fb_left, 1'b0};
      final_o = {word_i[31:1], word_i[0] | fb_left};
    end
  end

endmodule

`default_nettype wire
